// File: design/sbl_pkg.sv
// Package for the stable layer sorter: sizes, request type and codes.
// Used by every module of the block; depends on nothing.

package sbl_pkg;

    localparam int MAX_ITEMS   = 64;
    localparam int HANDLE_BITS = 16;
    localparam int LAYER_BITS  = 8;
    localparam int FILL_W      = $clog2(MAX_ITEMS + 1);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = QPTR_W + 1;

    // request kinds
    localparam logic KIND_INSERT = 1'b0;
    localparam logic KIND_CLOSE  = 1'b1;

    typedef struct packed {
        logic [LAYER_BITS-1:0]  layer;
        logic [HANDLE_BITS-1:0] handle;
        logic                   kind;
    } req_t;

    typedef struct packed {
        logic valid;
        logic full;
    } q_status_t;

endpackage

// File: design/sbl_front.sv
// Front stage: takes requests on the command port and classifies them.
// Depends on sbl_pkg; feeds sbl_queue.

module sbl_front
    import sbl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [LAYER_BITS-1:0]  item_layer,
    input  logic [HANDLE_BITS-1:0] item_handle,
    input  logic                   last_item,
    input  q_status_t              q_status,
    output logic                   push,
    output req_t                   push_req
);

    logic front_valid_reg;
    logic front_valid_next;
    req_t front_req_reg;
    logic accept;

    assign busy     = front_valid_reg && q_status.full;
    assign accept   = start && !busy;
    assign push     = front_valid_reg && !q_status.full;
    assign push_req = front_req_reg;

    always_comb
    begin
        front_valid_next = front_valid_reg;
        if (accept)
        begin
            front_valid_next = 1'b1;
        end
        else if (push)
        begin
            front_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_valid_reg <= 1'b0;
        end
        else
        begin
            front_valid_reg <= front_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            front_req_reg.layer  <= item_layer;
            front_req_reg.handle <= item_handle;
            front_req_reg.kind   <= last_item ? KIND_CLOSE : KIND_INSERT;
        end
    end

endmodule

// File: design/sbl_queue.sv
// Short request queue between front and back stages.
// Depends on sbl_pkg.

module sbl_queue
    import sbl_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      push,
    input  req_t      push_req,
    input  logic      pop,
    output req_t      pop_req,
    output q_status_t q_status
);

    req_t              entries_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] wr_ptr_next;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_next;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;
    logic              do_push;
    logic              do_pop;

    assign q_status.valid = (count_reg != '0);
    assign q_status.full  = (count_reg == QCNT_W'(QUEUE_DEPTH));
    assign do_push        = push && !q_status.full;
    assign do_pop         = pop && q_status.valid;
    assign pop_req        = entries_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entries_reg[wr_ptr_reg] <= push_req;
        end
    end

endmodule

// File: design/sbl_back.sv
// Back stage: row of compare-and-shift cells holding the sorted run, and
// the emission sequencer. Depends on sbl_pkg; fed by sbl_queue.

module sbl_back
    import sbl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   q_valid,
    input  req_t                   q_req,
    output logic                   pop,
    output logic                   out_valid,
    output logic [LAYER_BITS-1:0]  out_layer,
    output logic [HANDLE_BITS-1:0] out_handle,
    output logic                   out_last,
    output logic                   overflow
);

    localparam logic ST_RUN  = 1'b0;
    localparam logic ST_EMIT = 1'b1;

    logic                   state_reg;
    logic                   state_next;
    logic [FILL_W-1:0]      fill_reg;
    logic [FILL_W-1:0]      fill_next;
    logic                   dropped_reg;
    logic                   dropped_next;

    logic [LAYER_BITS-1:0]  keys_reg     [MAX_ITEMS];
    logic [LAYER_BITS-1:0]  keys_next    [MAX_ITEMS];
    logic [HANDLE_BITS-1:0] handles_reg  [MAX_ITEMS];
    logic [HANDLE_BITS-1:0] handles_next [MAX_ITEMS];
    logic [MAX_ITEMS-1:0]   gt;

    logic                   out_valid_reg;
    logic                   out_last_reg;
    logic                   overflow_reg;
    logic [LAYER_BITS-1:0]  out_layer_reg;
    logic [HANDLE_BITS-1:0] out_handle_reg;

    logic                   is_full;
    logic                   do_insert;
    logic                   emitting;

    assign pop       = (state_reg == ST_RUN) && q_valid;
    assign is_full   = (fill_reg == FILL_W'(MAX_ITEMS));
    assign do_insert = pop && !is_full;
    assign emitting  = (state_reg == ST_EMIT);

    // cells holding a key above the new one move up a place
    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            gt[i] = (FILL_W'(i) < fill_reg) && (keys_reg[i] > q_req.layer);
        end
    end

    always_comb
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            keys_next[i]    = keys_reg[i];
            handles_next[i] = handles_reg[i];
            if (emitting)
            begin
                if (i < MAX_ITEMS - 1)
                begin
                    keys_next[i]    = keys_reg[(i < MAX_ITEMS - 1) ? i + 1 : i];
                    handles_next[i] = handles_reg[(i < MAX_ITEMS - 1) ? i + 1 : i];
                end
            end
            else if (do_insert)
            begin
                if (i > 0 && gt[(i > 0) ? i - 1 : 0])
                begin
                    keys_next[i]    = keys_reg[(i > 0) ? i - 1 : 0];
                    handles_next[i] = handles_reg[(i > 0) ? i - 1 : 0];
                end
                else if (gt[i] || FILL_W'(i) == fill_reg)
                begin
                    keys_next[i]    = q_req.layer;
                    handles_next[i] = q_req.handle;
                end
            end
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        fill_next    = fill_reg;
        dropped_next = dropped_reg;
        case (state_reg)
            ST_RUN:
            begin
                if (pop)
                begin
                    if (is_full)
                    begin
                        dropped_next = 1'b1;
                    end
                    else
                    begin
                        fill_next = fill_reg + 1'b1;
                    end
                    if (q_req.kind == KIND_CLOSE)
                    begin
                        state_next = ST_EMIT;
                    end
                end
            end
            ST_EMIT:
            begin
                fill_next = fill_reg - 1'b1;
                if (fill_reg == FILL_W'(1))
                begin
                    state_next   = ST_RUN;
                    dropped_next = 1'b0;
                end
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            fill_reg      <= '0;
            dropped_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            fill_reg      <= fill_next;
            dropped_reg   <= dropped_next;
            out_valid_reg <= emitting;
            out_last_reg  <= emitting && (fill_reg == FILL_W'(1));
            overflow_reg  <= emitting && dropped_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        for (int i = 0; i < MAX_ITEMS; i++)
        begin
            keys_reg[i]    <= keys_next[i];
            handles_reg[i] <= handles_next[i];
        end
        if (emitting)
        begin
            out_layer_reg  <= keys_reg[0];
            out_handle_reg <= handles_reg[0];
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_last   = out_last_reg;
    assign overflow   = overflow_reg;
    assign out_layer  = out_layer_reg;
    assign out_handle = out_handle_reg;

endmodule

// File: design/stable_sort_by_layer_top.sv
// Top level of the stable layer sorter: front, request queue and sort cells.
// Depends on sbl_pkg, sbl_front, sbl_queue, sbl_back.
//
//   channel   handshake              payload
//   request   start / busy           item_layer, item_handle, last_item
//   result    out_valid (strobe)     out_layer, out_handle, out_last, overflow
//
// A request is taken when start is high and busy is low; the front register
// and a four-entry queue absorb requests while the back stage is emitting.
// The cell row inserts one queued record per cycle while not emitting. A closing
// record starts emission of one result per stored record on consecutive cycles,
// the first after the state and output registers. Results cannot be stalled.
// Reset empties the queue and the store; no clearing pass is needed.

module stable_sort_by_layer_top
    import sbl_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   start,
    output logic                   busy,
    input  logic [LAYER_BITS-1:0]  item_layer,
    input  logic [HANDLE_BITS-1:0] item_handle,
    input  logic                   last_item,
    output logic                   out_valid,
    output logic [LAYER_BITS-1:0]  out_layer,
    output logic [HANDLE_BITS-1:0] out_handle,
    output logic                   out_last,
    output logic                   overflow
);

    q_status_t q_status;
    logic      push;
    req_t      push_req;
    logic      pop;
    req_t      pop_req;

    sbl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .item_layer  (item_layer),
        .item_handle (item_handle),
        .last_item   (last_item),
        .q_status    (q_status),
        .push        (push),
        .push_req    (push_req)
    );

    sbl_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .pop_req  (pop_req),
        .q_status (q_status)
    );

    sbl_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_valid    (q_status.valid),
        .q_req      (pop_req),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_layer  (out_layer),
        .out_handle (out_handle),
        .out_last   (out_last),
        .overflow   (overflow)
    );

endmodule

// File: design/sbl_checker.sv
// Port-level checks for the stable layer sorter, bound to the top level.
// Depends on sbl_pkg and stable_sort_by_layer_top.

module sbl_checker
    import sbl_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   out_valid,
    input logic [LAYER_BITS-1:0]  out_layer,
    input logic                   out_last,
    input logic                   overflow
);

    // final mark only on a result
    a_last_valid: assert property (@(posedge clk) disable iff (!rst_n)
        out_last |-> out_valid)
        else $error("out_last without out_valid");

    // a run is emitted on consecutive cycles
    a_run_contig: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |=> out_valid)
        else $error("gap inside an emitted run");

    // layers ascend within a run
    a_run_sorted: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |=> (out_layer >= $past(out_layer)))
        else $error("emitted run not in layer order");

    // overflow is one value for the whole run
    a_run_ovf: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_last) |=> (overflow == $past(overflow)))
        else $error("overflow changed inside a run");

endmodule

bind stable_sort_by_layer_top sbl_checker u_sbl_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .out_valid (out_valid),
    .out_layer (out_layer),
    .out_last  (out_last),
    .overflow  (overflow)
);
